### src/srr_pkg.sv
// Shared types, constants and the round-robin pick function for the sonar ranger.
// No dependencies; used by srr_sched and sonar_round_robin_ranger_top.
package srr_pkg;

  // Number of rangers in the rotation (index fields are two bits wide)
  localparam int SONAR_COUNT = 3;

  localparam logic [1:0] NO_SONAR = 2'd3;

  // Ranging phase codes
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_WAIT = 2'd1;
  localparam logic [1:0] PHASE_DONE = 2'd2;

  // Item opcodes
  localparam logic OP_POLL = 1'b0;
  localparam logic OP_ECHO = 1'b1;

  // Configuration register indexes
  localparam logic REG_SONAR_MASK = 1'b0;
  localparam logic REG_TIMEOUT_US = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd30000;

  // Mask bits at or above SONAR_COUNT are ignored
  localparam logic [2:0] ENABLE_LIMIT = 3'((1 << SONAR_COUNT) - 1);

  typedef struct packed {
    logic        opcode;
    logic [1:0]  echo_sonar;
    logic [31:0] now_us;
  } item_t;

  typedef struct packed {
    logic        trigger_fire;
    logic [1:0]  trigger_sonar;
    logic        record_valid;
    logic [1:0]  record_sonar;
    logic [31:0] echo_time;
    logic        no_echo;
  } result_t;

  // Next enabled sonar after cur, circularly; from sonar 0 when none active
  function automatic logic [1:0] pick_next(logic [1:0] cur, logic [2:0] mask);
    logic [2:0] start;
    logic [2:0] idx;
    logic [1:0] res;
    logic       found;
    start = ({1'b0, cur} < 3'(SONAR_COUNT)) ? ({1'b0, cur} + 3'd1) : 3'd0;
    res   = 2'd0;
    found = 1'b0;
    for (int k = 0; k < SONAR_COUNT; k++) begin
      idx = start + 3'(k);
      if (idx >= 3'(SONAR_COUNT)) begin
        idx = idx - 3'(SONAR_COUNT);
      end
      if (!found && mask[idx[1:0]]) begin
        res   = idx[1:0];
        found = 1'b1;
      end
    end
    return res;
  endfunction

endpackage

### src/srr_sched.sv
// Ranging scheduler: holds the active sonar, phase and ping time, and turns
// one registered item into one result. Depends on srr_pkg.
module srr_sched (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  srr_pkg::item_t  item,
  input  logic [2:0]      sonar_mask,
  input  logic [15:0]     timeout_us,
  output srr_pkg::result_t result
);
  import srr_pkg::*;

  logic [1:0]  current_sonar, current_sonar_next;
  logic [1:0]  ranging_phase, ranging_phase_next;
  logic [31:0] ping_time, ping_time_next;

  logic [2:0]  enabled;
  logic [31:0] elapsed;
  logic        active;
  logic [1:0]  phase_mid;

  assign enabled = sonar_mask & ENABLE_LIMIT;
  assign elapsed = item.now_us - ping_time;
  assign active  = ({1'b0, current_sonar} < 3'(SONAR_COUNT));

  // Next state and result for the item
  always_comb begin
    current_sonar_next = current_sonar;
    ranging_phase_next = ranging_phase;
    ping_time_next     = ping_time;
    phase_mid          = ranging_phase;
    result             = '0;
    if (item.opcode == OP_POLL) begin
      // timeout check
      if (ranging_phase == PHASE_WAIT && active && (elapsed > {16'd0, timeout_us})) begin
        result.record_valid = 1'b1;
        result.record_sonar = current_sonar;
        result.no_echo      = 1'b1;
        phase_mid           = PHASE_DONE;
      end
      ranging_phase_next = phase_mid;
      if (enabled != 3'd0) begin
        if (phase_mid != PHASE_WAIT) begin
          current_sonar_next   = pick_next(current_sonar, enabled);
          result.trigger_fire  = 1'b1;
          result.trigger_sonar = current_sonar_next;
          ping_time_next       = item.now_us;
          ranging_phase_next   = PHASE_WAIT;
        end
      end else begin
        current_sonar_next = NO_SONAR;
        ranging_phase_next = PHASE_IDLE;
      end
    end else begin
      // echo only counts for the active, waiting sonar
      if (ranging_phase == PHASE_WAIT && item.echo_sonar == current_sonar && active) begin
        result.record_valid = 1'b1;
        result.record_sonar = current_sonar;
        result.echo_time    = elapsed;
        ranging_phase_next  = PHASE_DONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_sonar <= NO_SONAR;
      ranging_phase <= PHASE_IDLE;
      ping_time     <= 32'd0;
    end else if (go) begin
      current_sonar <= current_sonar_next;
      ranging_phase <= ranging_phase_next;
      ping_time     <= ping_time_next;
    end
  end

endmodule

### src/sonar_round_robin_ranger_top.sv
// Top level of the round-robin sonar ranger: handshake registers and config.
// Depends on srr_pkg and srr_sched.
//
// Schedules three ultrasonic rangers in round robin over sonar_mask. Each
// accepted item (a poll carrying the microsecond time, or an echo edge) gives
// exactly one result: an input register feeds the scheduler, whose result lands
// in the output register. One item can be taken every cycle; the rate is
// limited only by out_stall. A poll may record a no-echo timeout and fire the
// next trigger in the same result. Configuration writes take effect on the next
// cycle and are meant for when the block is idle.
module sonar_round_robin_ranger_top (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [1:0]  echo_sonar,
  input  logic [31:0] now_us,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        trigger_fire,
  output logic [1:0]  trigger_sonar,
  output logic        record_valid,
  output logic [1:0]  record_sonar,
  output logic [31:0] echo_time,
  output logic        no_echo
);
  import srr_pkg::*;

  logic [2:0]  sonar_mask;
  logic [15:0] timeout_us;

  logic        s1_valid;
  item_t       s1_item;
  logic        s1_move;
  logic        in_take;
  result_t     step_result;
  result_t     out_reg;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sonar_mask <= 3'd0;
      timeout_us <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SONAR_MASK: sonar_mask <= cfg_data[2:0];
        REG_TIMEOUT_US: timeout_us <= cfg_data;
        default: ;
      endcase
    end
  end

  // transfer control: input register moves into output register when it is free
  assign s1_move  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_move;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item.opcode     <= opcode;
      s1_item.echo_sonar <= echo_sonar;
      s1_item.now_us     <= now_us;
    end
  end

  srr_sched u_sched (
    .clk        (clk),
    .rst        (rst),
    .go         (s1_move),
    .item       (s1_item),
    .sonar_mask (sonar_mask),
    .timeout_us (timeout_us),
    .result     (step_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_reg <= step_result;
    end
  end

  assign trigger_fire  = out_reg.trigger_fire;
  assign trigger_sonar = out_reg.trigger_sonar;
  assign record_valid  = out_reg.record_valid;
  assign record_sonar  = out_reg.record_sonar;
  assign echo_time     = out_reg.echo_time;
  assign no_echo       = out_reg.no_echo;

endmodule
